>>> sv/vifd_pkg.sv
// vifd_pkg: shared types, constants and the size-code lookup for the
// vliw instruction format decoder; no dependencies
package vifd_pkg;

    localparam int SLOT_COUNT = 5;
    localparam int CODE_W     = 2;

    localparam logic [5:0] SIZE_NOP = 6'd0;
    localparam logic [5:0] SIZE_24  = 6'd24;
    localparam logic [5:0] SIZE_32  = 6'd32;
    localparam logic [5:0] SIZE_40  = 6'd40;

    localparam logic [7:0] FORMAT_BITS    = 8'd16;
    localparam logic [7:0] GROUP_PAD_BITS = 8'd8;
    localparam logic [2:0] GROUP_LIMIT    = 3'd3;
    localparam logic [2:0] OFFSET_LIMIT   = 3'd2;

    typedef enum logic [1:0] {
        CODE_24  = 2'd0,
        CODE_32  = 2'd1,
        CODE_40  = 2'd2,
        CODE_NOP = 2'd3
    } code_t;

    function automatic logic [5:0] size_of_code(input code_t code);
        logic [5:0] sz;
        unique case (code)
            CODE_24:  sz = SIZE_24;
            CODE_32:  sz = SIZE_32;
            CODE_40:  sz = SIZE_40;
            CODE_NOP: sz = SIZE_NOP;
            default:  sz = SIZE_NOP;
        endcase
        return sz;
    endfunction

endpackage

>>> sv/vliw_instruction_format_decode_top.sv
// vliw_instruction_format_decode_top: format field decoder with input
// register, single-pass decode logic and result register; uses vifd_pkg
//
// usage: an input beat carries a 16-bit format field and the slot number
// being asked about; every input beat yields exactly one output beat with
// the slot's operation size, its index among the real operations, the bit
// offsets of its 24-bit part and of its extension bytes (both counted after
// the format field), the instruction length and the operation count.
// slot numbers 5 to 7 read as an absent nop slot past the last one.
// path: the input register loads on the edge that accepts the beat, and
// the result register loads from it once the output side can advance.
// throughput: one beat per cycle while out_ready is high, sustained, with
// no bubbles; the decode is a short adder chain over five slots between
// the two registers.
// reset: rst_n clears both valid flags; no state survives between beats.
// stall: while out_ready is low the result register holds; the input
// register still takes one more beat, and in_ready drops only when both
// registers are full.
module vliw_instruction_format_decode_top
    import vifd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] format_field,
    input  logic [2:0]  slot_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  op_size_bits,
    output logic [2:0]  real_op_index,
    output logic [6:0]  op_bit_offset,
    output logic [7:0]  ext_bit_offset,
    output logic [7:0]  instr_length_bits,
    output logic [2:0]  op_count
);

    logic        s1_valid_reg;
    logic [15:0] fmt_reg;
    logic [2:0]  slot_reg;

    logic        out_valid_reg;
    logic [5:0]  size_reg;
    logic [2:0]  index_reg;
    logic [6:0]  op_off_reg;
    logic [7:0]  ext_off_reg;
    logic [7:0]  len_reg;
    logic [2:0]  count_reg;

    logic        adv_out;

    logic [5:0]  size_next;
    logic [2:0]  index_next;
    logic [6:0]  op_off_next;
    logic [7:0]  ext_off_next;
    logic [7:0]  len_next;
    logic [2:0]  count_next;

    logic [5:0]  sz;
    logic [6:0]  ext_below;

    assign adv_out  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv_out;

    always_comb
    begin
        count_next = 3'd0;
        index_next = 3'd0;
        ext_below  = 7'd0;
        len_next   = FORMAT_BITS;
        size_next  = SIZE_NOP;
        sz         = SIZE_NOP;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            sz = size_of_code(code_t'(fmt_reg[CODE_W*i +: CODE_W]));
            if (sz != SIZE_NOP)
            begin
                count_next = count_next + 3'd1;
                len_next   = len_next + {2'b00, sz};
                if (3'(i) < slot_reg)
                begin
                    index_next = index_next + 3'd1;
                    ext_below  = ext_below + {1'b0, sz - SIZE_24};
                end
            end
            if (3'(i) == slot_reg)
            begin
                size_next = sz;
            end
        end
        if (count_next > GROUP_LIMIT)
        begin
            len_next = len_next + GROUP_PAD_BITS;
        end

        op_off_next = 7'd0;
        if (size_next != SIZE_NOP)
        begin
            op_off_next = 7'(24 * index_next);
            if (index_next > OFFSET_LIMIT)
            begin
                op_off_next = op_off_next + 7'(GROUP_PAD_BITS);
            end
        end

        ext_off_next = 8'd0;
        if (size_next > SIZE_24)
        begin
            ext_off_next = 8'(24 * count_next) + {1'b0, ext_below};
            if (count_next > GROUP_LIMIT)
            begin
                ext_off_next = ext_off_next + GROUP_PAD_BITS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fmt_reg  <= format_field;
            slot_reg <= slot_number;
        end
        if (s1_valid_reg && adv_out)
        begin
            size_reg    <= size_next;
            index_reg   <= index_next;
            op_off_reg  <= op_off_next;
            ext_off_reg <= ext_off_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign op_size_bits      = size_reg;
    assign real_op_index     = index_reg;
    assign op_bit_offset     = op_off_reg;
    assign ext_bit_offset    = ext_off_reg;
    assign instr_length_bits = len_reg;
    assign op_count          = count_reg;

endmodule
